>>> sv/plugboard_connectivity_evaluator_unit_defines.svh
// Assertion macros for the plugboard connectivity evaluator checker.
// No dependencies; included by files that carry assertions.
`ifndef PLUGBOARD_CONNECTIVITY_EVALUATOR_UNIT_DEFINES_SVH
`define PLUGBOARD_CONNECTIVITY_EVALUATOR_UNIT_DEFINES_SVH

// checked only outside reset
`define PCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define PCE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/pce_pkg.sv
// Shared types, constants and helper functions of the plugboard evaluator.
// No dependencies.
package pce_pkg;

  localparam int NCOLS  = 20;
  localparam int NROWS  = 11;
  localparam int NNODES = NCOLS * NROWS;
  localparam int NHOLES = NNODES * 3;
  localparam int NSW    = 10;

  localparam int NODE_W = 8;
  localparam int HOLE_W = 10;
  localparam int LINK_W = HOLE_W + 1;
  localparam int SP_W   = 8;

  localparam logic [NODE_W-1:0] SUPPLY_NODE = NODE_W'(10);
  localparam logic [NODE_W-1:0] BTN_NODE_L  = NODE_W'(11 * NROWS + 10);
  localparam logic [NODE_W-1:0] BTN_NODE_R  = NODE_W'(12 * NROWS + 10);
  localparam logic [4:0]        BTN_COL_L   = 5'd11;
  localparam logic [4:0]        BTN_COL_R   = 5'd12;

  typedef enum logic [1:0] {
    CMD_CONNECT = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_SWITCH  = 2'd2,
    CMD_BUTTON  = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_WIRED     = 2'd1,
    ST_IDENTICAL = 2'd2,
    ST_NO_WIRE   = 2'd3
  } status_code_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RD_B, S_CHK, S_WR_A, S_WR_B,
    S_RM_CHK, S_RM_A, S_RM_T, S_APPLY, S_FL_INIT, S_FL_POP,
    S_FL_NODE, S_FL_H0, S_FL_H1, S_FL_H2, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_LATCH, OP_RD_A, OP_RD_B, OP_CHECK, OP_WR_A, OP_WR_B,
    OP_RM_CHECK, OP_RM_A, OP_RM_T, OP_APPLY, OP_FL_INIT, OP_FL_POP,
    OP_FL_NODE, OP_FL_HOLE
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] hole;   // link slot consumed by OP_FL_HOLE
  } dp_ctl_t;

  typedef struct packed {
    logic      clr_last;
    logic      refuse;
    logic      rm_ok;
    logic      sp_zero;
    logic      out_free;
    cmd_code_t cmd;
  } dp_stat_t;

  // node / 11 by reciprocal, exact for node < 220
  function automatic logic [4:0] node_col(input logic [NODE_W-1:0] n);
    logic [16:0] p;
    p = 17'(n) * 17'd373;
    return p[16:12];
  endfunction

  // hole / 3 by reciprocal, exact for hole < 660
  function automatic logic [NODE_W-1:0] hole_node(input logic [HOLE_W-1:0] t);
    logic [18:0] p;
    p = 19'(t) * 19'd683;
    return p[18:11];
  endfunction

  function automatic logic [HOLE_W-1:0] hole_index(input logic [4:0] col,
                                                   input logic [3:0] row,
                                                   input logic [1:0] hole);
    logic [NODE_W-1:0] nd;
    nd = NODE_W'(col) * NODE_W'(NROWS) + NODE_W'(row);
    return HOLE_W'(nd) * HOLE_W'(3) + HOLE_W'(hole) - HOLE_W'(1);
  endfunction

endpackage

>>> sv/pce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/pce_ctrl.sv
// Sequencer of the plugboard evaluator: command steps, flood loop, result hand-off.
// Depends on pce_pkg.
module pce_ctrl
  import pce_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_ctl_t  ctl
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:   if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE:    if (in_tvalid) state_nxt = S_DECODE;
      S_DECODE: begin
        unique case (stat.cmd)
          CMD_CONNECT: state_nxt = S_RD_B;
          CMD_REMOVE:  state_nxt = S_RM_CHK;
          default:     state_nxt = S_APPLY;
        endcase
      end
      S_RD_B:    state_nxt = S_CHK;
      S_CHK:     state_nxt = stat.refuse ? S_FL_INIT : S_WR_A;
      S_WR_A:    state_nxt = S_WR_B;
      S_WR_B:    state_nxt = S_FL_INIT;
      S_RM_CHK:  state_nxt = stat.rm_ok ? S_RM_A : S_FL_INIT;
      S_RM_A:    state_nxt = S_RM_T;
      S_RM_T:    state_nxt = S_FL_INIT;
      S_APPLY:   state_nxt = S_FL_INIT;
      S_FL_INIT: state_nxt = S_FL_POP;
      S_FL_POP:  state_nxt = stat.sp_zero ? S_DONE : S_FL_NODE;
      S_FL_NODE: state_nxt = S_FL_H0;
      S_FL_H0:   state_nxt = S_FL_H1;
      S_FL_H1:   state_nxt = S_FL_H2;
      S_FL_H2:   state_nxt = S_FL_POP;
      S_DONE:    if (stat.out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    ctl.op    = OP_NONE;
    ctl.hole  = 2'd0;
    unique case (state_r)
      S_CLEAR:   ctl.op = OP_CLEAR;
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) ctl.op = OP_LATCH;
      end
      S_DECODE:  ctl.op = OP_RD_A;
      S_RD_B:    ctl.op = OP_RD_B;
      S_CHK:     ctl.op = OP_CHECK;
      S_WR_A:    ctl.op = OP_WR_A;
      S_WR_B:    ctl.op = OP_WR_B;
      S_RM_CHK:  ctl.op = OP_RM_CHECK;
      S_RM_A:    ctl.op = OP_RM_A;
      S_RM_T:    ctl.op = OP_RM_T;
      S_APPLY:   ctl.op = OP_APPLY;
      S_FL_INIT: ctl.op = OP_FL_INIT;
      S_FL_POP:  if (!stat.sp_zero) ctl.op = OP_FL_POP;
      S_FL_NODE: ctl.op = OP_FL_NODE;
      S_FL_H0: begin
        ctl.op   = OP_FL_HOLE;
        ctl.hole = 2'd0;
      end
      S_FL_H1: begin
        ctl.op   = OP_FL_HOLE;
        ctl.hole = 2'd1;
      end
      S_FL_H2: begin
        ctl.op   = OP_FL_HOLE;
        ctl.hole = 2'd2;
      end
      S_DONE:    ctl.op = OP_NONE;
      default:   ctl.op = OP_NONE;
    endcase
  end
endmodule

>>> sv/pce_dp.sv
// Datapath of the plugboard evaluator: link memory, flood stack, powered bits,
// switch/button state and the result register. Depends on pce_pkg, pce_ram.
module pce_dp
  import pce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  input  dp_ctl_t     ctl,
  output dp_stat_t    stat
);
  // latched command
  cmd_code_t         cmd_r;
  logic [HOLE_W-1:0] a_r, b_r, t_r;
  logic              av_r, bv_r;
  logic [3:0]        swi_r;
  logic              lvl_r;
  logic [LINK_W-1:0] la_r;
  status_code_t      status_r;

  logic [NSW-1:0]    sw_r;
  logic              btn_r;
  logic [HOLE_W-1:0] clr_cnt_r;

  logic [NNODES-1:0] pow_r;
  logic [SP_W-1:0]   sp_r;
  logic [NODE_W-1:0] node_r;

  logic              out_valid_r;
  logic [15:0]       out_data_r;

  // result pending flag: set when the flood starts, cleared when the result is loaded
  logic              load_pend_r;
  logic              load_now;

  // memories
  logic              lk_we;
  logic [HOLE_W-1:0] lk_waddr, lk_raddr;
  logic [LINK_W-1:0] lk_wdata, lk_rdata;
  logic              wl_we;
  logic [NODE_W-1:0] wl_waddr, wl_raddr, wl_wdata, wl_rdata;

  pce_ram #(.WIDTH(LINK_W), .DEPTH(NHOLES)) u_links (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(lk_raddr), .rdata(lk_rdata)
  );

  pce_ram #(.WIDTH(NODE_W), .DEPTH(NNODES)) u_stack (
    .clk(clk), .we(wl_we), .waddr(wl_waddr), .wdata(wl_wdata),
    .raddr(wl_raddr), .rdata(wl_rdata)
  );

  // input field decode
  logic [4:0] in_col_a, in_col_b;
  logic [3:0] in_row_a, in_row_b;
  logic [1:0] in_hole_a, in_hole_b;
  logic       in_av, in_bv;

  assign in_col_a  = in_tdata[6:2];
  assign in_row_a  = in_tdata[10:7];
  assign in_hole_a = in_tdata[12:11];
  assign in_col_b  = in_tdata[17:13];
  assign in_row_b  = in_tdata[21:18];
  assign in_hole_b = in_tdata[23:22];
  assign in_av = (in_col_a < 5'(NCOLS)) && (in_row_a < 4'(NROWS)) && (in_hole_a != 2'd0);
  assign in_bv = (in_col_b < 5'(NCOLS)) && (in_row_b < 4'(NROWS)) && (in_hole_b != 2'd0);

  // flood node decode; the node comes straight off the stack read port
  logic [4:0]        nd_col;
  logic [3:0]        nd_row;
  logic [NODE_W-1:0] nd_rowfull;
  logic [NODE_W-1:0] fixed_peer;
  logic              fixed_join;
  logic [HOLE_W-1:0] node3;

  assign nd_col     = node_col(wl_rdata);
  assign nd_rowfull = wl_rdata - NODE_W'(nd_col) * NODE_W'(NROWS);
  assign nd_row     = nd_rowfull[3:0];
  assign node3      = HOLE_W'(node_r) * HOLE_W'(3);

  always_comb begin
    fixed_join = 1'b0;
    fixed_peer = BTN_NODE_L;
    if (nd_row < 4'd10) begin
      // switch link to the paired column; on joins even rows, off joins odd rows
      fixed_join = sw_r[nd_col[4:1]] ? !nd_row[0] : nd_row[0];
      fixed_peer = NODE_W'({nd_col[4:1], ~nd_col[0]}) * NODE_W'(NROWS) + NODE_W'(nd_row);
    end else if (btn_r) begin
      fixed_join = (nd_col == BTN_COL_L) || (nd_col == BTN_COL_R);
      fixed_peer = (nd_col == BTN_COL_L) ? BTN_NODE_R : BTN_NODE_L;
    end
  end

  // single push point into the flood stack, apart from the supply node written at init
  logic              push_en;
  logic [NODE_W-1:0] push_node;
  logic              push_ok;

  always_comb begin
    push_en   = 1'b0;
    push_node = fixed_peer;
    if (ctl.op == OP_FL_NODE) begin
      push_en = fixed_join;
    end else if (ctl.op == OP_FL_HOLE) begin
      push_en   = lk_rdata[LINK_W-1] && (lk_rdata[HOLE_W-1:0] < HOLE_W'(NHOLES));
      push_node = hole_node(lk_rdata[HOLE_W-1:0]);
    end
  end
  assign push_ok = push_en && (push_node < NODE_W'(NNODES)) && !pow_r[push_node];

  // connect verdict, identical ends first
  status_code_t chk_status;
  always_comb begin
    if (av_r && bv_r && (a_r == b_r)) begin
      chk_status = ST_IDENTICAL;
    end else if (!av_r || !bv_r || la_r[LINK_W-1] || lk_rdata[LINK_W-1]) begin
      chk_status = ST_WIRED;
    end else begin
      chk_status = ST_DONE;
    end
  end

  // memory port muxes
  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = a_r;
    lk_wdata = '0;
    lk_raddr = '0;
    wl_we    = push_ok;
    wl_waddr = sp_r;
    wl_wdata = push_node;
    wl_raddr = sp_r - SP_W'(1);
    case (ctl.op)
      OP_CLEAR: begin
        lk_we    = 1'b1;
        lk_waddr = clr_cnt_r;
      end
      OP_RD_A:   lk_raddr = a_r;
      OP_RD_B:   lk_raddr = b_r;
      OP_WR_A: begin
        lk_we    = 1'b1;
        lk_wdata = {1'b1, b_r};
      end
      OP_WR_B: begin
        lk_we    = 1'b1;
        lk_waddr = b_r;
        lk_wdata = {1'b1, a_r};
      end
      OP_RM_A:   lk_we = 1'b1;
      OP_RM_T: begin
        lk_we    = (t_r < HOLE_W'(NHOLES));
        lk_waddr = t_r;
      end
      OP_FL_INIT: begin
        wl_we    = 1'b1;
        wl_waddr = '0;
        wl_wdata = SUPPLY_NODE;
      end
      OP_FL_NODE: lk_raddr = HOLE_W'(wl_rdata) * HOLE_W'(3);
      OP_FL_HOLE: lk_raddr = node3 + HOLE_W'(ctl.hole) + HOLE_W'(1);
      default: ;
    endcase
  end

  // result assembly
  logic [NSW-1:0] lamps;
  always_comb begin
    for (int x = 0; x < NSW; x++) begin
      lamps[x] = pow_r[(x + 1) * NROWS + 10];
    end
  end

  // result load: flood finished (controller idles on the empty stack) and out_ is free
  assign load_now = load_pend_r && stat.sp_zero && (ctl.op == OP_NONE) && stat.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      sw_r        <= '0;
      btn_r       <= 1'b0;
      pow_r       <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.op == OP_CLEAR) clr_cnt_r <= clr_cnt_r + HOLE_W'(1);
      if (ctl.op == OP_APPLY) begin
        if (cmd_r == CMD_SWITCH) begin
          if (swi_r < 4'(NSW)) sw_r[swi_r] <= lvl_r;
        end else begin
          btn_r <= lvl_r;
        end
      end
      if (ctl.op == OP_FL_INIT) begin
        pow_r <= NNODES'(1) << SUPPLY_NODE;
        sp_r  <= SP_W'(1);
      end else if (ctl.op == OP_FL_POP) begin
        sp_r <= sp_r - SP_W'(1);
      end else if (push_ok) begin
        pow_r[push_node] <= 1'b1;
        sp_r             <= sp_r + SP_W'(1);
      end
      if (load_now) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pend_r <= 1'b0;
    end else if (ctl.op == OP_FL_INIT) begin
      load_pend_r <= 1'b1;
    end else if (load_now) begin
      load_pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_LATCH) begin
      cmd_r    <= cmd_code_t'(in_tdata[1:0]);
      av_r     <= in_av;
      bv_r     <= in_bv;
      a_r      <= in_av ? hole_index(in_col_a, in_row_a, in_hole_a) : '0;
      b_r      <= in_bv ? hole_index(in_col_b, in_row_b, in_hole_b) : '0;
      swi_r    <= in_tdata[27:24];
      lvl_r    <= in_tdata[28];
      status_r <= ST_DONE;
    end
    if (ctl.op == OP_RD_B) la_r <= lk_rdata;
    if (ctl.op == OP_CHECK) status_r <= chk_status;
    if (ctl.op == OP_RM_CHECK) begin
      t_r <= lk_rdata[HOLE_W-1:0];
      if (!(av_r && lk_rdata[LINK_W-1])) status_r <= ST_NO_WIRE;
    end
    if (ctl.op == OP_FL_NODE) node_r <= wl_rdata;
    if (load_now) begin
      out_data_r <= {4'd0, status_r, lamps};
    end
  end

  assign stat.clr_last = (clr_cnt_r == HOLE_W'(NHOLES - 1));
  assign stat.refuse   = (chk_status != ST_DONE);
  assign stat.rm_ok    = av_r && lk_rdata[LINK_W-1];
  assign stat.sp_zero  = (sp_r == '0);
  assign stat.out_free = !out_valid_r || out_tready;
  assign stat.cmd      = cmd_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
endmodule

>>> sv/plugboard_connectivity_evaluator_unit.sv
// Top level of the plugboard connectivity evaluator.
// Depends on pce_pkg, pce_ctrl, pce_dp (which holds two pce_ram instances).
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  in_     | in  | in_tvalid/in_tready  | in_tdata[31:0], one command
//  out_    | out | out_tvalid/out_tready| out_tdata[15:0], lamps and status
//
// One command at a time. The wiring step is followed by the flood, which for
// each powered node does a stack pop, a node read and three link reads on the
// single read port of the link memory. After reset a clearing pass writes all
// 660 link entries, one per cycle, with in_tready low. The result sits in an
// output register; a stalled out_ side holds the block in its final step until
// that result is taken.
module plugboard_connectivity_evaluator_unit
  import pce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] cmd, [6:2] col_a, [10:7] row_a, [12:11] hole_a, [17:13] col_b,
  // [21:18] row_b, [23:22] hole_b, [27:24] switch_index, [28] level, rest zero
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [9:0] lamp_mask, [11:10] status, rest zero
  output logic [15:0] out_tdata
);
  dp_ctl_t  ctl;
  dp_stat_t stat;

  // sequencer: steps each command through its read/check/write or apply steps, then the flood loop
  pce_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .stat(stat), .ctl(ctl)
  );

  // storage and arithmetic; the transfer on out_ is owned here
  pce_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .ctl(ctl), .stat(stat)
  );
endmodule

>>> sv/pce_chk.sv
// Port-level checker for the plugboard evaluator, bound to the top level.
// Depends on plugboard_connectivity_evaluator_unit_defines.svh.
`include "plugboard_connectivity_evaluator_unit_defines.svh"
module pce_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  `PCE_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped")
  `PCE_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata), "result changed")
  `PCE_ASSERT(a_busy, in_tvalid && in_tready |=> !in_tready, "second command taken")
  `PCE_ASSERT(a_pad, out_tvalid |-> out_tdata[15:12] == 4'd0, "padding not zero")
  `PCE_ASSERT_ALWAYS(a_rst, !rst_n |=> !in_tready && !out_tvalid, "reset state")
endmodule

bind plugboard_connectivity_evaluator_unit pce_chk u_pce_chk (.*);

>>> tb/testbench.sv
// Self-checking testbench for plugboard_connectivity_evaluator_unit.
// Depends on pce_pkg and the RTL; predicts lamp mask and status per command.
`timescale 1ns / 1ps

module testbench
  import pce_pkg::*;
();

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] lamps;
  } board_result_t;

  // board model: links per hole, switches, button
  logic [10:0]   link_mem [NHOLES] = '{default: '0};
  logic [9:0]    sw_pos = '0;
  logic          btn = 1'b0;
  logic [31:0]   cmd_q[$];
  board_result_t lamp_q[$];
  int            fail_cnt = 0;
  bit            calm = 1'b0;     // no idling near the end
  bit            hold_go = 1'b0;  // long receiver hold-off request
  bit            hold_used = 1'b0;
  int            hold_left = 0;
  int            in_gap = 0;
  int            out_gap = 0;

  always #5 clk = ~clk;

  plugboard_connectivity_evaluator_unit u_top (.*);

  function automatic int hole_num(logic [4:0] c, logic [3:0] r, logic [1:0] h);
    if (c >= NCOLS || r >= NROWS || h == 2'd0) return -1;
    return (int'(c) * NROWS + int'(r)) * 3 + int'(h) - 1;
  endfunction

  // flood from the supply node, then read the lamp row
  function automatic logic [9:0] lamp_flood();
    bit pw [NNODES];
    int stk [NNODES];
    int sp, n, c, r, t;
    logic [9:0] m;
    foreach (pw[i]) pw[i] = 1'b0;
    pw[SUPPLY_NODE] = 1'b1;
    stk[0] = int'(SUPPLY_NODE);
    sp = 1;
    while (sp > 0) begin
      sp = sp - 1;
      n = stk[sp];
      c = n / NROWS;
      r = n % NROWS;
      t = -1;
      if (r < 10) begin
        if (sw_pos[c >> 1] ? (r % 2 == 0) : (r % 2 == 1)) t = (c ^ 1) * NROWS + r;
      end else if (btn) begin
        if (c == 11) t = int'(BTN_NODE_R);
        else if (c == 12) t = int'(BTN_NODE_L);
      end
      if (t >= 0 && !pw[t]) begin
        pw[t] = 1'b1;
        stk[sp] = t;
        sp = sp + 1;
      end
      for (int h = 0; h < 3; h++) begin
        if (link_mem[n*3+h][10]) begin
          t = int'(link_mem[n*3+h][9:0]) / 3;
          if (!pw[t]) begin
            pw[t] = 1'b1;
            stk[sp] = t;
            sp = sp + 1;
          end
        end
      end
    end
    for (int x = 0; x < 10; x++) m[x] = pw[(x+1)*NROWS + 10];
    return m;
  endfunction

  function automatic board_result_t board_step(logic [31:0] d);
    board_result_t res;
    cmd_code_t  op;
    int a, b;
    op = cmd_code_t'(d[1:0]);
    a = hole_num(d[6:2], d[10:7], d[12:11]);
    b = hole_num(d[17:13], d[21:18], d[23:22]);
    res.status = ST_DONE;
    case (op)
      CMD_CONNECT: begin
        if (a >= 0 && a == b) res.status = ST_IDENTICAL;
        else if (a < 0 || b < 0 || link_mem[a][10] || link_mem[b][10])
          res.status = ST_WIRED;
        else begin
          link_mem[a] = {1'b1, 10'(b)};
          link_mem[b] = {1'b1, 10'(a)};
        end
      end
      CMD_REMOVE: begin
        if (a < 0 || !link_mem[a][10]) res.status = ST_NO_WIRE;
        else begin
          link_mem[link_mem[a][9:0]] = '0;
          link_mem[a] = '0;
        end
      end
      CMD_SWITCH: if (d[27:24] < NSW) sw_pos[d[27:24]] = d[28];
      default: btn = d[28];
    endcase
    res.lamps = lamp_flood();
    return res;
  endfunction

  function automatic logic [31:0] pack_cmd(cmd_code_t op, logic [4:0] ca, logic [3:0] ra,
                                           logic [1:0] ha, logic [4:0] cb, logic [3:0] rb,
                                           logic [1:0] hb, logic [3:0] si, logic lv);
    return {3'b0, lv, si, hb, rb, cb, ha, ra, ca, op};
  endfunction

  // append one command to the pending queue
  task automatic add_cmd(input logic [31:0] v);
    cmd_q = {cmd_q, v};
  endtask

  // random hole, mostly valid, sometimes out of range
  task automatic rand_hole(output logic [4:0] c, output logic [3:0] r, output logic [1:0] h);
    if ($urandom_range(0, 15) == 0) begin
      c = 5'($urandom);
      r = 4'($urandom);
      h = 2'($urandom);
    end else begin
      c = 5'($urandom_range(0, 19));
      r = 4'($urandom_range(0, 10));
      h = 2'($urandom_range(1, 3));
    end
  endtask

  // driver: one transfer per handshake, random gaps
  always @(posedge clk) begin
    logic          take;
    board_result_t exp_v;
    if (rst_n) begin
      take = in_tvalid && in_tready;
      if (take) begin
        cmd_q.pop_front();
        exp_v = board_step(in_tdata);
        lamp_q = {lamp_q, exp_v};
      end
      if (take && !calm && $urandom_range(0, 3) == 0) begin
        in_gap    <= int'($urandom_range(0, 9));
        in_tvalid <= 1'b0;
      end else if (in_gap > 0) begin
        in_gap    <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= cmd_q[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= 3000;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    board_result_t exp_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (lamp_q.size() == 0) begin
          $error("unexpected result %h", out_tdata);
          fail_cnt++;
        end else begin
          exp_r = lamp_q.pop_front();
          if (out_tdata[9:0] !== exp_r.lamps) begin
            $error("lamp_mask exp %h got %h", exp_r.lamps, out_tdata[9:0]);
            fail_cnt++;
          end
          if (out_tdata[11:10] !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, out_tdata[11:10]);
            fail_cnt++;
          end
          if (out_tdata[15:12] !== 4'b0) begin
            $error("pad exp 0 got %h", out_tdata[15:12]);
            fail_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) out_gap <= $urandom_range(1, 10);
      end
    end
  end

  initial begin
    logic [4:0] ca, cb;
    logic [3:0] ra, rb;
    logic [1:0] ha, hb;
    int k;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, each command, each refusal
    add_cmd(pack_cmd(CMD_CONNECT, 0, 10, 1, 1, 10, 1, 0, 0));   // supply to lamp 0
    add_cmd(pack_cmd(CMD_CONNECT, 0, 10, 1, 0, 10, 1, 0, 0));   // identical ends
    add_cmd(pack_cmd(CMD_CONNECT, 0, 10, 1, 19, 0, 3, 0, 0));   // already wired
    add_cmd(pack_cmd(CMD_CONNECT, 31, 15, 0, 31, 15, 0, 15, 1)); // invalid both
    add_cmd(pack_cmd(CMD_CONNECT, 20, 0, 1, 20, 0, 1, 0, 0));   // invalid identical
    add_cmd(pack_cmd(CMD_CONNECT, 19, 0, 3, 19, 11, 2, 0, 0));  // row out of range
    add_cmd(pack_cmd(CMD_CONNECT, 0, 10, 2, 11, 10, 1, 0, 0));  // to button left
    add_cmd(pack_cmd(CMD_BUTTON, 0, 0, 0, 0, 0, 0, 0, 1));
    add_cmd(pack_cmd(CMD_CONNECT, 12, 10, 1, 2, 10, 3, 0, 0));
    add_cmd(pack_cmd(CMD_CONNECT, 0, 10, 3, 0, 0, 1, 0, 0));    // supply to grid
    add_cmd(pack_cmd(CMD_SWITCH, 0, 0, 0, 0, 0, 0, 0, 1));
    add_cmd(pack_cmd(CMD_CONNECT, 1, 0, 1, 3, 10, 1, 0, 0));
    add_cmd(pack_cmd(CMD_SWITCH, 0, 0, 0, 0, 0, 0, 9, 1));
    add_cmd(pack_cmd(CMD_SWITCH, 0, 0, 0, 0, 0, 0, 15, 1));     // index out of range
    add_cmd(pack_cmd(CMD_SWITCH, 0, 0, 0, 0, 0, 0, 0, 0));
    add_cmd(pack_cmd(CMD_BUTTON, 0, 0, 0, 0, 0, 0, 0, 0));
    add_cmd(pack_cmd(CMD_REMOVE, 1, 10, 1, 0, 0, 0, 0, 0));     // far end
    add_cmd(pack_cmd(CMD_REMOVE, 1, 10, 1, 0, 0, 0, 0, 0));     // nothing there
    add_cmd(pack_cmd(CMD_REMOVE, 31, 15, 0, 0, 0, 0, 0, 0));    // invalid end
    add_cmd(pack_cmd(CMD_BUTTON, 31, 15, 3, 31, 15, 3, 15, 1));
    wait (cmd_q.size() == 0);

    // long receiver hold-off while the sender keeps offering
    hold_go = 1'b1;
    for (int i = 0; i < 20; i++) begin
      rand_hole(ca, ra, ha);
      rand_hole(cb, rb, hb);
      add_cmd(pack_cmd(CMD_CONNECT, ca, ra, ha, cb, rb, hb, 4'($urandom), 1'($urandom)));
    end
    wait (cmd_q.size() == 0);

    // random part: mostly wiring, switches flip often
    for (int i = 0; i < 830; i++) begin
      if (i == 760) begin
        wait (cmd_q.size() == 0);
        calm = 1'b1;
      end
      rand_hole(ca, ra, ha);
      rand_hole(cb, rb, hb);
      k = $urandom_range(0, 9);
      add_cmd(pack_cmd(k < 5 ? CMD_CONNECT : k < 7 ? CMD_REMOVE :
                       k < 9 ? CMD_SWITCH : CMD_BUTTON,
                       ca, ra, ha, cb, rb, hb,
                       $urandom_range(0, 15) == 0 ? 4'($urandom) : 4'($urandom_range(0, 9)),
                       1'($urandom)));
      if (cmd_q.size() > 8) wait (cmd_q.size() < 4);
    end
    wait (cmd_q.size() == 0 && !in_tvalid);
    wait (lamp_q.size() == 0);
    repeat (1200) @(posedge clk);
    if (fail_cnt == 0 && lamp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
